### rtl/lqd_pkg.sv
// Shared constants, record type and reference table generator for the lock-in demodulator.
package lqd_pkg;

   localparam int MAX_RECORD  = 65536;
   localparam int TABLE_BITS  = 10;
   localparam int SAMPLE_BITS = 16;

   localparam int SAMPLE_IN_W = 16;
   localparam int PHASE_W     = 32;
   localparam int USED_W      = 17;
   localparam int COMP_W      = 32;
   localparam int ACC_W       = 48;
   localparam int REF_W       = 16;
   localparam int PROD_W      = SAMPLE_BITS + REF_W;
   localparam int LIMIT_W     = $clog2(MAX_RECORD + 1);
   localparam int DIV_W       = $clog2(MAX_RECORD / 2 + 1);

   localparam int TAB_SIZE    = 1 << TABLE_BITS;
   localparam int QUARTER     = 1 << (TABLE_BITS - 2);
   localparam int QIDX_W      = TABLE_BITS - 2;

   localparam logic [63:0] PI_Q30  = 64'd3373259426;
   localparam logic [63:0] Q30_ONE = 64'd1 << 30;
   localparam logic [63:0] REF_ONE = 64'd32767;

   localparam int REC_DEPTH   = 2;

   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_SEL_BIT = 2;
   localparam logic REG_PHASE_STEP   = 1'b0;
   localparam logic REG_USED_SAMPLES = 1'b1;

   typedef struct packed {
      logic [ACC_W-1:0] sine_sum;
      logic [ACC_W-1:0] cosine_sum;
      logic [DIV_W-1:0] divisor;
   } rec_type;

   // Quarter-wave reference entry j in Q1.15, from a Taylor series in Q30.
   // Only ever evaluated at elaboration to build the constant table.
   function automatic logic [REF_W-1:0] quarter_ref(input int unsigned j);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] d;
      logic [63:0] s;
      logic [63:0] r;
      x  = (64'd2 * PI_Q30 * 64'(j) + 64'(TAB_SIZE >> 1)) >> TABLE_BITS;
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      d  = ((x2 * t) >> 30) / 64'd210;
      t  = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
      d  = ((x2 * t) >> 30) / 64'd156;
      t  = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
      d  = ((x2 * t) >> 30) / 64'd110;
      t  = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
      d  = ((x2 * t) >> 30) / 64'd72;
      t  = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
      d  = ((x2 * t) >> 30) / 64'd42;
      t  = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
      d  = ((x2 * t) >> 30) / 64'd20;
      t  = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
      d  = ((x2 * t) >> 30) / 64'd6;
      t  = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
      s  = (x * t) >> 30;
      if (s > Q30_ONE) begin
         s = Q30_ONE;
      end
      r = (s * REF_ONE + (64'd1 << 29)) >> 30;
      return r[REF_W-1:0];
   endfunction

endpackage

### rtl/lqd_front.sv
// Front end: sample intake, phase accumulator, reference lookup and correlation sums.
module lqd_front
   import lqd_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [SAMPLE_IN_W-1:0]        req_sample,
   input  logic                          req_end_of_record,
   input  logic [PHASE_W-1:0]            phase_step,
   input  logic [USED_W-1:0]             used_samples,
   output logic                          rec_push,
   output rec_type                       rec_data,
   input  logic                          rec_full
);

   // Quarter-wave table, entries 0 .. QUARTER-1; the peak entry is kept apart.
   localparam logic [REF_W-1:0] QTOP = quarter_ref(QUARTER);

   logic [REF_W-1:0] qtab [QUARTER];

   for (genvar g = 0; g < QUARTER; g++) begin : g_qtab
      localparam logic [REF_W-1:0] QV = quarter_ref(g);
      assign qtab[g] = QV;
   end

   // Maps a full-table index onto the quarter table: {negate, peak, index}.
   function automatic logic [QIDX_W+1:0] fold_index(input logic [TABLE_BITS-1:0] k);
      logic [1:0]        quad;
      logic [QIDX_W-1:0] r;
      logic [QIDX_W-1:0] mirrored;
      quad     = k[TABLE_BITS-1 -: 2];
      r        = k[QIDX_W-1:0];
      mirrored = QIDX_W'(~r + QIDX_W'(1));
      if (quad[0]) begin
         return {quad[1], (r == '0), mirrored};
      end
      return {quad[1], 1'b0, r};
   endfunction

   logic                          adv;
   logic                          accept;
   logic [PHASE_W-1:0]            phase_next;
   logic [LIMIT_W-1:0]            limit;
   logic                          active;

   logic [PHASE_W-1:0]            phase_acc_ff, phase_acc_in;
   logic [LIMIT_W-1:0]            sample_index_ff, sample_index_in;

   logic                          s1_valid_ff, s1_valid_in;
   logic signed [SAMPLE_BITS-1:0] s1_sample_ff, s1_sample_in;
   logic [TABLE_BITS-1:0]         s1_idx_ff, s1_idx_in;
   logic                          s1_active_ff, s1_active_in;
   logic                          s1_eor_ff, s1_eor_in;
   logic [DIV_W-1:0]              s1_div_ff, s1_div_in;

   logic                          s2_valid_ff, s2_valid_in;
   logic signed [SAMPLE_BITS-1:0] s2_sample_ff, s2_sample_in;
   logic signed [REF_W-1:0]       s2_sref_ff, s2_sref_in;
   logic signed [REF_W-1:0]       s2_cref_ff, s2_cref_in;
   logic                          s2_active_ff, s2_active_in;
   logic                          s2_eor_ff, s2_eor_in;
   logic [DIV_W-1:0]              s2_div_ff, s2_div_in;

   logic                          s3_valid_ff, s3_valid_in;
   logic signed [PROD_W-1:0]      s3_sprod_ff, s3_sprod_in;
   logic signed [PROD_W-1:0]      s3_cprod_ff, s3_cprod_in;
   logic                          s3_active_ff, s3_active_in;
   logic                          s3_eor_ff, s3_eor_in;
   logic [DIV_W-1:0]              s3_div_ff, s3_div_in;

   logic [ACC_W-1:0]              sine_acc_ff, sine_acc_in;
   logic [ACC_W-1:0]              cosine_acc_ff, cosine_acc_in;
   logic [ACC_W-1:0]              sine_sum;
   logic [ACC_W-1:0]              cosine_sum;

   logic [QIDX_W+1:0]             sfold;
   logic [QIDX_W+1:0]             cfold;
   logic [REF_W-1:0]              smag;
   logic [REF_W-1:0]              cmag;

   // The pipeline only halts when a finished record cannot enter the queue.
   assign adv    = !(s3_valid_ff && s3_eor_ff && rec_full);
   assign full   = !adv;
   assign accept = push && adv;

   always_comb begin
      phase_next = phase_acc_ff + phase_step;
      limit      = (32'(used_samples) > 32'(MAX_RECORD)) ? LIMIT_W'(MAX_RECORD)
                                                          : LIMIT_W'(used_samples);
      active     = (sample_index_ff < limit);

      phase_acc_in    = phase_acc_ff;
      sample_index_in = sample_index_ff;
      if (accept) begin
         if (req_end_of_record) begin
            phase_acc_in    = '0;
            sample_index_in = '0;
         end else begin
            phase_acc_in = phase_next;
            if (active) begin
               sample_index_in = sample_index_ff + LIMIT_W'(1);
            end
         end
      end

      s1_valid_in  = adv ? accept : s1_valid_ff;
      s1_sample_in = s1_sample_ff;
      s1_idx_in    = s1_idx_ff;
      s1_active_in = s1_active_ff;
      s1_eor_in    = s1_eor_ff;
      s1_div_in    = s1_div_ff;
      if (adv) begin
         s1_sample_in = req_sample[SAMPLE_BITS-1:0];
         s1_idx_in    = phase_next[PHASE_W-1 -: TABLE_BITS];
         s1_active_in = active;
         s1_eor_in    = req_end_of_record;
         s1_div_in    = DIV_W'(limit >> 1);
      end
   end

   always_comb begin
      sfold = fold_index(s1_idx_ff);
      cfold = fold_index(s1_idx_ff + TABLE_BITS'(QUARTER));
      smag  = sfold[QIDX_W] ? QTOP : qtab[sfold[QIDX_W-1:0]];
      cmag  = cfold[QIDX_W] ? QTOP : qtab[cfold[QIDX_W-1:0]];

      s2_valid_in  = adv ? s1_valid_ff : s2_valid_ff;
      s2_sample_in = s2_sample_ff;
      s2_sref_in   = s2_sref_ff;
      s2_cref_in   = s2_cref_ff;
      s2_active_in = s2_active_ff;
      s2_eor_in    = s2_eor_ff;
      s2_div_in    = s2_div_ff;
      if (adv) begin
         s2_sample_in = s1_sample_ff;
         s2_sref_in   = sfold[QIDX_W+1] ? REF_W'(REF_W'(0) - smag) : smag;
         s2_cref_in   = cfold[QIDX_W+1] ? REF_W'(REF_W'(0) - cmag) : cmag;
         s2_active_in = s1_active_ff;
         s2_eor_in    = s1_eor_ff;
         s2_div_in    = s1_div_ff;
      end
   end

   always_comb begin
      s3_valid_in  = adv ? s2_valid_ff : s3_valid_ff;
      s3_sprod_in  = s3_sprod_ff;
      s3_cprod_in  = s3_cprod_ff;
      s3_active_in = s3_active_ff;
      s3_eor_in    = s3_eor_ff;
      s3_div_in    = s3_div_ff;
      if (adv) begin
         s3_sprod_in  = PROD_W'(s2_sample_ff) * PROD_W'(s2_sref_ff);
         s3_cprod_in  = PROD_W'(s2_sample_ff) * PROD_W'(s2_cref_ff);
         s3_active_in = s2_active_ff;
         s3_eor_in    = s2_eor_ff;
         s3_div_in    = s2_div_ff;
      end
   end

   always_comb begin
      sine_sum   = sine_acc_ff + (s3_active_ff ? ACC_W'(s3_sprod_ff) : '0);
      cosine_sum = cosine_acc_ff + (s3_active_ff ? ACC_W'(s3_cprod_ff) : '0);

      sine_acc_in   = sine_acc_ff;
      cosine_acc_in = cosine_acc_ff;
      if (s3_valid_ff && adv) begin
         sine_acc_in   = s3_eor_ff ? '0 : sine_sum;
         cosine_acc_in = s3_eor_ff ? '0 : cosine_sum;
      end

      rec_push            = s3_valid_ff && s3_eor_ff && !rec_full;
      rec_data.sine_sum   = sine_sum;
      rec_data.cosine_sum = cosine_sum;
      rec_data.divisor    = s3_div_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_acc_ff    <= '0;
         sample_index_ff <= '0;
         sine_acc_ff     <= '0;
         cosine_acc_ff   <= '0;
         s1_valid_ff     <= 1'b0;
         s2_valid_ff     <= 1'b0;
         s3_valid_ff     <= 1'b0;
      end else begin
         phase_acc_ff    <= phase_acc_in;
         sample_index_ff <= sample_index_in;
         sine_acc_ff     <= sine_acc_in;
         cosine_acc_ff   <= cosine_acc_in;
         s1_valid_ff     <= s1_valid_in;
         s2_valid_ff     <= s2_valid_in;
         s3_valid_ff     <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_sample_ff <= s1_sample_in;
      s1_idx_ff    <= s1_idx_in;
      s1_active_ff <= s1_active_in;
      s1_eor_ff    <= s1_eor_in;
      s1_div_ff    <= s1_div_in;
      s2_sample_ff <= s2_sample_in;
      s2_sref_ff   <= s2_sref_in;
      s2_cref_ff   <= s2_cref_in;
      s2_active_ff <= s2_active_in;
      s2_eor_ff    <= s2_eor_in;
      s2_div_ff    <= s2_div_in;
      s3_sprod_ff  <= s3_sprod_in;
      s3_cprod_ff  <= s3_cprod_in;
      s3_active_ff <= s3_active_in;
      s3_eor_ff    <= s3_eor_in;
      s3_div_ff    <= s3_div_in;
   end

endmodule

### rtl/lqd_rec_queue.sv
// Short queue of finished record sums between the front end and the divider.
module lqd_rec_queue
   import lqd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rec_type push_data,
   output logic    full,
   input  logic    pop,
   output rec_type pop_data,
   output logic    empty
);

   localparam int PTR_W = (REC_DEPTH > 1) ? $clog2(REC_DEPTH) : 1;
   localparam int CNT_W = $clog2(REC_DEPTH + 1);

   rec_type           entry_ff [REC_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full     = (count_ff == CNT_W'(REC_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(REC_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(REC_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/lqd_back.sv
// Back end: bit-serial signed division of both sums, saturation and the result register.
module lqd_back
   import lqd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              rec_empty,
   input  rec_type           rec_data,
   output logic              rec_pop,
   output logic              empty,
   input  logic              pop,
   output logic [COMP_W-1:0] rsp_sine_component,
   output logic [COMP_W-1:0] rsp_cosine_component,
   output logic              rsp_invalid
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   localparam int COUNT_W = $clog2(ACC_W);

   localparam logic [ACC_W-1:0]  NEG_LIMIT = ACC_W'(64'd1 << (COMP_W - 1));
   localparam logic [ACC_W-1:0]  POS_LIMIT = NEG_LIMIT - ACC_W'(1);
   localparam logic [COMP_W-1:0] COMP_MIN  = {1'b1, {(COMP_W - 1){1'b0}}};
   localparam logic [COMP_W-1:0] COMP_MAX  = {1'b0, {(COMP_W - 1){1'b1}}};

   // One restoring step: returns {remainder, shifted dividend with new quotient bit}.
   function automatic logic [DIV_W+ACC_W-1:0] div_step(input logic [DIV_W-1:0] rem,
                                                      input logic [ACC_W-1:0] dvd,
                                                      input logic [DIV_W-1:0] dsr);
      logic [DIV_W:0] shifted;
      logic           bit_q;
      logic [DIV_W:0] diff;
      shifted = {rem, dvd[ACC_W-1]};
      bit_q   = (shifted >= {1'b0, dsr});
      diff    = shifted - {1'b0, dsr};
      return {bit_q ? diff[DIV_W-1:0] : shifted[DIV_W-1:0], dvd[ACC_W-2:0], bit_q};
   endfunction

   function automatic logic [COMP_W-1:0] saturate(input logic neg,
                                                 input logic [ACC_W-1:0] mag);
      logic [ACC_W-1:0] negated;
      negated = ACC_W'(0) - mag;
      if (neg) begin
         return (mag > NEG_LIMIT) ? COMP_MIN : negated[COMP_W-1:0];
      end
      return (mag > POS_LIMIT) ? COMP_MAX : mag[COMP_W-1:0];
   endfunction

   logic [1:0]          state_ff, state_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [DIV_W-1:0]    div_ff, div_in;
   logic [ACC_W-1:0]    sine_dvd_ff, sine_dvd_in;
   logic [ACC_W-1:0]    cos_dvd_ff, cos_dvd_in;
   logic [DIV_W-1:0]    sine_rem_ff, sine_rem_in;
   logic [DIV_W-1:0]    cos_rem_ff, cos_rem_in;
   logic                sine_neg_ff, sine_neg_in;
   logic                cos_neg_ff, cos_neg_in;
   logic                out_valid_ff, out_valid_in;
   logic [COMP_W-1:0]   out_sine_ff, out_sine_in;
   logic [COMP_W-1:0]   out_cos_ff, out_cos_in;
   logic                out_invalid_ff, out_invalid_in;

   logic                load;
   logic                step;
   logic                out_load;
   logic [DIV_W+ACC_W-1:0] sine_next;
   logic [DIV_W+ACC_W-1:0] cos_next;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      rec_pop  = 1'b0;
      load     = 1'b0;
      step     = 1'b0;
      out_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!rec_empty) begin
               rec_pop  = 1'b1;
               load     = 1'b1;
               count_in = '0;
               state_in = (rec_data.divisor == '0) ? ST_DONE : ST_DIV;
            end
         end
         ST_DIV: begin
            step = 1'b1;
            if (count_ff == COUNT_W'(ACC_W - 1)) begin
               state_in = ST_DONE;
            end else begin
               count_in = count_ff + COUNT_W'(1);
            end
         end
         ST_DONE: begin
            if (!out_valid_ff || pop) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      sine_next   = div_step(sine_rem_ff, sine_dvd_ff, div_ff);
      cos_next    = div_step(cos_rem_ff, cos_dvd_ff, div_ff);

      div_in      = div_ff;
      sine_dvd_in = sine_dvd_ff;
      cos_dvd_in  = cos_dvd_ff;
      sine_rem_in = sine_rem_ff;
      cos_rem_in  = cos_rem_ff;
      sine_neg_in = sine_neg_ff;
      cos_neg_in  = cos_neg_ff;
      if (load) begin
         div_in      = rec_data.divisor;
         sine_neg_in = rec_data.sine_sum[ACC_W-1];
         cos_neg_in  = rec_data.cosine_sum[ACC_W-1];
         sine_dvd_in = rec_data.sine_sum[ACC_W-1] ? ACC_W'(0) - rec_data.sine_sum
                                                  : rec_data.sine_sum;
         cos_dvd_in  = rec_data.cosine_sum[ACC_W-1] ? ACC_W'(0) - rec_data.cosine_sum
                                                    : rec_data.cosine_sum;
         sine_rem_in = '0;
         cos_rem_in  = '0;
      end else if (step) begin
         sine_rem_in = sine_next[DIV_W+ACC_W-1 -: DIV_W];
         sine_dvd_in = sine_next[ACC_W-1:0];
         cos_rem_in  = cos_next[DIV_W+ACC_W-1 -: DIV_W];
         cos_dvd_in  = cos_next[ACC_W-1:0];
      end

      out_valid_in   = out_valid_ff;
      out_sine_in    = out_sine_ff;
      out_cos_in     = out_cos_ff;
      out_invalid_in = out_invalid_ff;
      if (out_load) begin
         out_valid_in   = 1'b1;
         out_invalid_in = (div_ff == '0);
         out_sine_in    = (div_ff == '0) ? '0 : saturate(sine_neg_ff, sine_dvd_ff);
         out_cos_in     = (div_ff == '0) ? '0 : saturate(cos_neg_ff, cos_dvd_ff);
      end else if (pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end
   end

   assign empty                = !out_valid_ff;
   assign rsp_sine_component   = out_sine_ff;
   assign rsp_cosine_component = out_cos_ff;
   assign rsp_invalid          = out_invalid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      div_ff         <= div_in;
      sine_dvd_ff    <= sine_dvd_in;
      cos_dvd_ff     <= cos_dvd_in;
      sine_rem_ff    <= sine_rem_in;
      cos_rem_ff     <= cos_rem_in;
      sine_neg_ff    <= sine_neg_in;
      cos_neg_ff     <= cos_neg_in;
      out_sine_ff    <= out_sine_in;
      out_cos_ff     <= out_cos_in;
      out_invalid_ff <= out_invalid_in;
   end

   // The partial remainders stay below the divisor throughout the division.
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (sine_rem_ff < div_ff) && (cos_rem_ff < div_ff))
      else $error("division remainder reached the divisor");

   // An invalid result always carries zero components.
   a_invalid_is_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_invalid_ff) |-> (out_sine_ff == '0) && (out_cos_ff == '0))
      else $error("invalid result with non-zero components");

   // A new result only appears after the divider has finished.
   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result loaded outside the finishing state");

endmodule

### rtl/lockin_quadrature_demodulator_top.sv
// Top level of the lock-in quadrature demodulator: register file and block assembly.
// Throughput: one sample transaction per clock cycle while full is low; each record
// then occupies the shared 48-step divider, and the two-entry record queue absorbs
// bursts. A record whose divisor is zero skips the division steps.
// Reset is synchronous and clears both registers, the phase, all sums and queues.
module lockin_quadrature_demodulator_top
   import lqd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  logic [SAMPLE_IN_W-1:0] req_sample,
   input  logic                   req_end_of_record,
   output logic                   empty,
   input  logic                   pop,
   output logic [COMP_W-1:0]      rsp_sine_component,
   output logic [COMP_W-1:0]      rsp_cosine_component,
   output logic                   rsp_invalid,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CSR_ADDR_W-1:0]  paddr,
   input  logic [CSR_DATA_W-1:0]  pwdata,
   output logic [CSR_DATA_W-1:0]  prdata,
   output logic                   pready
);

   // Configuration registers. The word index alone selects the register, so the
   // byte-offset bits of the address are not decoded. Writes are expected only
   // while no transaction is in flight, so no hazard checking is needed here.
   logic [PHASE_W-1:0] phase_step_ff, phase_step_in;
   logic [USED_W-1:0]  used_samples_ff, used_samples_in;
   logic               csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      phase_step_in   = phase_step_ff;
      used_samples_in = used_samples_ff;
      if (csr_write) begin
         case (paddr[CSR_SEL_BIT])
            REG_PHASE_STEP:   phase_step_in   = pwdata[PHASE_W-1:0];
            REG_USED_SAMPLES: used_samples_in = pwdata[USED_W-1:0];
            default:          phase_step_in   = phase_step_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[CSR_SEL_BIT])
         REG_PHASE_STEP:   prdata = CSR_DATA_W'(phase_step_ff);
         REG_USED_SAMPLES: prdata = CSR_DATA_W'(used_samples_ff);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff   <= '0;
         used_samples_ff <= '0;
      end else begin
         phase_step_ff   <= phase_step_in;
         used_samples_ff <= used_samples_in;
      end
   end

   // The front end runs one sample per cycle, unless stalled, through phase
   // accumulation, table lookup, multiplication and accumulation. At a record's end
   // it hands both sums and the divisor over as one record and clears its state.
   rec_type rec_in_data;
   rec_type rec_out_data;
   logic    rec_push;
   logic    rec_full;
   logic    rec_pop;
   logic    rec_empty;

   lqd_front u_front (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_sample        (req_sample),
      .req_end_of_record (req_end_of_record),
      .phase_step        (phase_step_ff),
      .used_samples      (used_samples_ff),
      .rec_push          (rec_push),
      .rec_data          (rec_in_data),
      .rec_full          (rec_full)
   );

   // The record queue decouples the sample stream from the slow divider, so that
   // a new record can be accumulated while the previous one is still dividing.
   lqd_rec_queue u_rec_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rec_push),
      .push_data (rec_in_data),
      .full      (rec_full),
      .pop       (rec_pop),
      .pop_data  (rec_out_data),
      .empty     (rec_empty)
   );

   // The back end divides both sums by the half count one quotient bit per cycle,
   // saturates them to 32 bits and holds the result until it is taken.
   lqd_back u_back (
      .clock                (clock),
      .reset                (reset),
      .rec_empty            (rec_empty),
      .rec_data             (rec_out_data),
      .rec_pop              (rec_pop),
      .empty                (empty),
      .pop                  (pop),
      .rsp_sine_component   (rsp_sine_component),
      .rsp_cosine_component (rsp_cosine_component),
      .rsp_invalid          (rsp_invalid)
   );

endmodule

### tb/lqd_correlation_checker.sv
// Checker for the lock-in demodulator: predicts the I/Q correlation results and compares them.
`timescale 1ns / 100ps
module lqd_correlation_checker
   import lqd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic                   full,
   input  logic [SAMPLE_IN_W-1:0] req_sample,
   input  logic                   req_end_of_record,
   input  logic                   empty,
   input  logic                   pop,
   input  logic [COMP_W-1:0]      rsp_sine_component,
   input  logic [COMP_W-1:0]      rsp_cosine_component,
   input  logic                   rsp_invalid,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic                   pready,
   input  logic [CSR_ADDR_W-1:0]  paddr,
   input  logic [CSR_DATA_W-1:0]  pwdata,
   output int                     error_count,
   output int                     pending
);

   localparam longint COMP_MAX = (longint'(1) << (COMP_W - 1)) - 1;
   localparam longint COMP_MIN = -(longint'(1) << (COMP_W - 1));

   typedef struct {
      logic [COMP_W-1:0] sine;
      logic [COMP_W-1:0] cosine;
      logic              invalid;
   } component_set_type;

   component_set_type expected_components[$];

   int sine_table [TAB_SIZE];

   logic [PHASE_W-1:0] phase_step;
   logic [USED_W-1:0]  used_samples;
   logic [PHASE_W-1:0] phase;
   logic [USED_W-1:0]  taken;
   logic [ACC_W-1:0]   sine_sum;
   logic [ACC_W-1:0]   cosine_sum;
   int                 mismatches;

   // Sine over the first quadrant in Q30 by a truncating Taylor series, scaled to Q1.15.
   function automatic int quarter_wave(input int unsigned j);
      logic [63:0] angle;
      logic [63:0] angle_sq;
      logic [63:0] series;
      logic [63:0] drop;
      logic [63:0] sine_q30;
      int unsigned taylor_div [7];
      taylor_div = '{210, 156, 110, 72, 42, 20, 6};
      angle    = (64'd2 * PI_Q30 * 64'(j) + 64'(TAB_SIZE / 2)) >> TABLE_BITS;
      angle_sq = (angle * angle) >> 30;
      series   = Q30_ONE;
      foreach (taylor_div[i]) begin
         drop   = ((angle_sq * series) >> 30) / 64'(taylor_div[i]);
         series = (drop >= Q30_ONE) ? 64'd0 : Q30_ONE - drop;
      end
      sine_q30 = (angle * series) >> 30;
      if (sine_q30 > Q30_ONE) begin
         sine_q30 = Q30_ONE;
      end
      return int'((sine_q30 * REF_ONE + (64'd1 << 29)) >> 30);
   endfunction

   initial begin : build_reference_table
      int first_quadrant [QUARTER + 1];
      int v;
      for (int j = 0; j <= QUARTER; j++) begin
         first_quadrant[j] = quarter_wave(j);
      end
      for (int k = 0; k < TAB_SIZE; k++) begin
         v = ((k & QUARTER) != 0) ? first_quadrant[QUARTER - (k % QUARTER)]
                                  : first_quadrant[k % QUARTER];
         sine_table[k] = ((k & (2 * QUARTER)) != 0) ? -v : v;
      end
   end

   function automatic logic [COMP_W-1:0] scaled_component(input logic [ACC_W-1:0] sum,
                                                          input longint divisor);
      longint quotient;
      quotient = longint'($signed(sum)) / divisor;
      if (quotient > COMP_MAX) begin
         quotient = COMP_MAX;
      end else if (quotient < COMP_MIN) begin
         quotient = COMP_MIN;
      end
      return quotient[COMP_W-1:0];
   endfunction

   // Advances the reference phase, correlates one sample and closes the record if marked.
   function automatic void correlate_sample(input logic [SAMPLE_IN_W-1:0] raw,
                                            input logic last);
      logic signed [SAMPLE_BITS-1:0] value;
      logic [USED_W-1:0]             limit;
      logic [TABLE_BITS-1:0]         sin_idx;
      logic [TABLE_BITS-1:0]         cos_idx;
      longint                        divisor;
      component_set_type             outcome;
      value   = raw[SAMPLE_BITS-1:0];
      limit   = (used_samples > MAX_RECORD) ? USED_W'(MAX_RECORD) : used_samples;
      phase   = phase + phase_step;
      sin_idx = phase[PHASE_W-1 -: TABLE_BITS];
      cos_idx = sin_idx + TABLE_BITS'(QUARTER);
      if (taken < limit) begin
         sine_sum   = sine_sum + ACC_W'(longint'(value) * sine_table[sin_idx]);
         cosine_sum = cosine_sum + ACC_W'(longint'(value) * sine_table[cos_idx]);
         taken      = taken + 1'b1;
      end
      if (last) begin
         divisor = longint'(limit >> 1);
         if (divisor == 0) begin
            outcome.sine    = '0;
            outcome.cosine  = '0;
            outcome.invalid = 1'b1;
         end else begin
            outcome.sine    = scaled_component(sine_sum, divisor);
            outcome.cosine  = scaled_component(cosine_sum, divisor);
            outcome.invalid = 1'b0;
         end
         expected_components.push_back(outcome);
         phase      = '0;
         taken      = '0;
         sine_sum   = '0;
         cosine_sum = '0;
      end
   endfunction

   always @(posedge clock) begin
      component_set_type due;
      if (reset) begin
         phase_step   = '0;
         used_samples = '0;
         phase        = '0;
         taken        = '0;
         sine_sum     = '0;
         cosine_sum   = '0;
         mismatches   = 0;
         expected_components.delete();
      end else begin
         // Results first, so a result leaving in the same cycle is never confused with a new one.
         if (pop && !empty) begin
            if (expected_components.size() == 0) begin
               $error("result transaction with nothing expected: sine %0d cosine %0d invalid %0b",
                      $signed(rsp_sine_component), $signed(rsp_cosine_component), rsp_invalid);
               mismatches++;
            end else begin
               due = expected_components.pop_front();
               if (rsp_sine_component !== due.sine) begin
                  $error("sine_component: expected %0d, actual %0d",
                         $signed(due.sine), $signed(rsp_sine_component));
                  mismatches++;
               end
               if (rsp_cosine_component !== due.cosine) begin
                  $error("cosine_component: expected %0d, actual %0d",
                         $signed(due.cosine), $signed(rsp_cosine_component));
                  mismatches++;
               end
               if (rsp_invalid !== due.invalid) begin
                  $error("invalid: expected %0b, actual %0b", due.invalid, rsp_invalid);
                  mismatches++;
               end
            end
         end
         // A sample taken in the same cycle as a register write still sees the old value.
         if (push && !full) begin
            correlate_sample(req_sample, req_end_of_record);
         end
         if (psel && penable && pwrite && pready) begin
            if (paddr[CSR_SEL_BIT] == REG_PHASE_STEP) begin
               phase_step = pwdata[PHASE_W-1:0];
            end else begin
               used_samples = pwdata[USED_W-1:0];
            end
         end
      end
      error_count <= mismatches;
      pending     <= expected_components.size();
   end

endmodule

### tb/lockin_quadrature_demodulator_top_test.sv
// Testbench top for the lock-in demodulator: clock, reset, stimulus, receiver and verdict.
`timescale 1ns / 100ps
module lockin_quadrature_demodulator_top_test
   import lqd_pkg::*;
();

   // Sizing of the run. A record ends in one result, so the random part also runs until
   // a few dozen records have been closed.
   localparam int RANDOM_ITEMS   = 600;
   localparam int MIN_RECORDS    = 40;
   localparam int QUIET_TAIL     = 80;
   // The drain covers the time from the end-of-record sample to its result.
   localparam int DRAIN_CYCLES   = 60;
   localparam int HOLD_CYCLES    = 400;
   // Longest correct spell without a transaction is the long receiver hold plus a drain.
   localparam int WATCHDOG_LIMIT = 4000;

   logic                   clock;
   logic                   reset;
   logic                   push;
   logic                   full;
   logic [SAMPLE_IN_W-1:0] req_sample;
   logic                   req_end_of_record;
   logic                   empty;
   logic                   pop;
   logic [COMP_W-1:0]      rsp_sine_component;
   logic [COMP_W-1:0]      rsp_cosine_component;
   logic                   rsp_invalid;
   logic                   psel;
   logic                   penable;
   logic                   pwrite;
   logic [CSR_ADDR_W-1:0]  paddr;
   logic [CSR_DATA_W-1:0]  pwdata;
   logic [CSR_DATA_W-1:0]  prdata;
   logic                   pready;

   int error_count;
   int pending;
   int idle_cycles;
   int items_sent;
   int records_sent;
   bit hold_request;
   bit quiet_tail;
   bit sender_idles;

   lockin_quadrature_demodulator_top dut (
      .clock                (clock),
      .reset                (reset),
      .push                 (push),
      .full                 (full),
      .req_sample           (req_sample),
      .req_end_of_record    (req_end_of_record),
      .empty                (empty),
      .pop                  (pop),
      .rsp_sine_component   (rsp_sine_component),
      .rsp_cosine_component (rsp_cosine_component),
      .rsp_invalid          (rsp_invalid),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .prdata               (prdata),
      .pready               (pready)
   );

   lqd_correlation_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .push                 (push),
      .full                 (full),
      .req_sample           (req_sample),
      .req_end_of_record    (req_end_of_record),
      .empty                (empty),
      .pop                  (pop),
      .rsp_sine_component   (rsp_sine_component),
      .rsp_cosine_component (rsp_cosine_component),
      .rsp_invalid          (rsp_invalid),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .pready               (pready),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .error_count          (error_count),
      .pending              (pending)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // The watchdog restarts on every transaction on any port; a block that hangs with
   // work outstanding lets it run out.
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || (psel && penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Drops push for a number of cycles. It is always called at a clock edge at which the
   // previous sample was accepted, so push sees one assignment per edge.
   task automatic pause_sender(input int cycles);
      push <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Offers one sample and holds it until the block takes it. Now and then a burst of
   // idle cycles goes ahead of it, unless the current stretch runs without gaps. Once
   // the run is into its last stretch, no more gaps are made.
   task automatic send_sample(input logic [SAMPLE_IN_W-1:0] value, input logic last);
      if (items_sent >= RANDOM_ITEMS - QUIET_TAIL) begin
         quiet_tail = 1'b1;
      end
      if (sender_idles && !quiet_tail && $urandom_range(0, 7) == 0) begin
         pause_sender($urandom_range(1, 12));
      end
      push              <= 1'b1;
      req_sample        <= value;
      req_end_of_record <= last;
      do @(posedge clock); while (full);
      items_sent++;
      if (last) begin
         records_sent++;
      end
   endtask

   // Stops offering samples until the checker has seen every result it expects. The
   // count it reports is registered, hence the wait before the first look.
   task automatic wait_for_results();
      push <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // One register write: a setup cycle, then the access cycle that lasts until pready.
   // The extra edge at the end keeps back-to-back writes from touching psel twice at once.
   task automatic write_register(input logic reg_sel, input logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(reg_sel) << CSR_SEL_BIT;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Registers are only written once the block has nothing left in flight. Every record
   // ends with a marked sample, yet the latency is still allowed to run out before the write.
   task automatic program_registers(input logic [PHASE_W-1:0] step_value,
                                    input logic [USED_W-1:0] used_value);
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      write_register(REG_PHASE_STEP, CSR_DATA_W'(step_value));
      write_register(REG_USED_SAMPLES, CSR_DATA_W'(used_value));
   endtask

   // Full-scale values turn up often, since they are where the sums saturate.
   function automatic logic [SAMPLE_IN_W-1:0] random_sample();
      case ($urandom_range(0, 7))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         default: return SAMPLE_IN_W'($urandom);
      endcase
   endfunction

   function automatic logic [PHASE_W-1:0] random_step();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return PHASE_W'(1) << $urandom_range(20, 31);
         default: return PHASE_W'($urandom);
      endcase
   endfunction

   // Short records keep the run brief; the longest count and those above it are still
   // visited, with records cut short by an early end-of-record mark.
   function automatic logic [USED_W-1:0] random_used();
      case ($urandom_range(0, 9))
         0:       return USED_W'($urandom_range(0, 1));
         1:       return USED_W'(MAX_RECORD);
         2:       return USED_W'($urandom_range(MAX_RECORD + 1, (1 << USED_W) - 1));
         default: return USED_W'($urandom_range(2, 48));
      endcase
   endfunction

   // The receiver pops freely, stalls in short random bursts, or, once, holds off for a
   // long stretch so that the block fills and pushes back on the sender.
   initial begin : result_receiver
      int cycles_in_mode;
      bit stalls_on;
      cycles_in_mode = 0;
      stalls_on      = 1'b1;
      pop <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         @(posedge clock);
         cycles_in_mode++;
         if (cycles_in_mode >= 150) begin
            cycles_in_mode = 0;
            stalls_on      = ($urandom_range(0, 2) != 0);
         end
         if (hold_request) begin
            pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else if (stalls_on && !quiet_tail && $urandom_range(0, 9) == 0) begin
            pop <= 1'b0;
            repeat ($urandom_range(1, 12) - 1) @(posedge clock);
         end else begin
            pop <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      int phase_no;
      int record_count;
      int record_length;
      logic [USED_W-1:0] used_value;
      push              <= 1'b0;
      req_sample        <= '0;
      req_end_of_record <= 1'b0;
      psel              <= 1'b0;
      penable           <= 1'b0;
      pwrite            <= 1'b0;
      paddr             <= '0;
      pwdata            <= '0;
      hold_request      = 1'b0;
      quiet_tail        = 1'b0;
      sender_idles      = 1'b1;
      items_sent        = 0;
      records_sent      = 0;
      reset <= 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. With a zero step every sample sees the cosine peak, so three
      // full-scale samples over a divisor of one push the cosine quotient past both limits.
      program_registers('0, 17'd3);
      send_sample(16'h7FFF, 1'b0);
      send_sample(16'h7FFF, 1'b0);
      send_sample(16'h7FFF, 1'b1);
      send_sample(16'h8000, 1'b0);
      send_sample(16'h8000, 1'b0);
      send_sample(16'h8000, 1'b1);
      // A count of zero or one leaves no divisor: the result is flagged invalid.
      program_registers('0, 17'd0);
      send_sample(16'h1234, 1'b1);
      program_registers('0, 17'd1);
      send_sample(16'hFFFF, 1'b0);
      send_sample(16'h0001, 1'b1);
      // Count above the record limit, and a record that ends well short of its count.
      program_registers('1, '1);
      send_sample(16'h8000, 1'b0);
      send_sample(16'h7FFF, 1'b0);
      send_sample(16'h5555, 1'b0);
      send_sample(16'hAAAA, 1'b1);
      // Samples past the count still turn the phase but add nothing.
      program_registers(32'h8000_0000, 17'd2);
      send_sample(16'h7FFF, 1'b0);
      send_sample(16'h8000, 1'b0);
      send_sample(16'h1111, 1'b0);
      send_sample(16'h2222, 1'b0);
      send_sample(16'h3333, 1'b1);
      // Exactly the longest record count.
      program_registers(32'h1234_5678, USED_W'(MAX_RECORD));
      send_sample(16'h0000, 1'b0);
      send_sample(16'hFFFF, 1'b0);
      send_sample(16'h8001, 1'b1);

      // Random part: phases of one register setting each, several records per phase.
      items_sent   = 0;
      records_sent = 0;
      phase_no     = 0;
      while (items_sent < RANDOM_ITEMS || records_sent < MIN_RECORDS) begin
         quiet_tail   = (items_sent >= RANDOM_ITEMS - QUIET_TAIL);
         sender_idles = ($urandom_range(0, 2) != 0);
         if (phase_no == 2) begin
            // Back-pressure phase: many short records while the receiver holds off.
            sender_idles = 1'b0;
            program_registers(PHASE_W'($urandom), 17'd4);
            hold_request = 1'b1;
            repeat (24) begin
               send_sample(random_sample(), 1'b0);
               send_sample(random_sample(), 1'b1);
            end
         end else begin
            used_value = random_used();
            program_registers(random_step(), used_value);
            record_count = $urandom_range(1, 6);
            repeat (record_count) begin
               record_length = (used_value <= 48) ? $urandom_range(1, used_value + 6)
                                                  : $urandom_range(1, 64);
               for (int k = 1; k <= record_length; k++) begin
                  send_sample(random_sample(), k == record_length);
               end
            end
         end
         phase_no++;
      end

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/lqd_pkg.sv
rtl/lqd_front.sv
rtl/lqd_rec_queue.sv
rtl/lqd_back.sv
rtl/lockin_quadrature_demodulator_top.sv
tb/lqd_correlation_checker.sv
tb/lockin_quadrature_demodulator_top_test.sv
